// ===== rtl/vn3_pkg.sv =====
// Shared widths, constants and result word type for the 3D vector normalize unit.
`default_nettype none
package vn3_pkg;

    localparam int COMP_W  = 32;            // input component width, Q16.16
    localparam int MAG_W   = 32;            // component magnitude width
    localparam int SUM_W   = 64;            // sum of squares width, Q32.32
    localparam int QUO_W   = 63;            // quotient width of sq * 2^62 / S
    localparam int ROOT_W  = 32;            // square root width
    localparam int NCOMP   = 3;             // vector components
    localparam int SB_W    = NCOMP + 1;     // sign bits plus zero flag

    localparam logic [COMP_W-1:0] ONE_Q230  = 32'h4000_0000;
    localparam logic [COMP_W-1:0] ONE_Q1616 = 32'h0001_0000;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic        [COMP_W-1:0] length;
        logic                     was_zero;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/vector_normalise_3d_unit.sv =====
// Top level of the 3D vector normalize unit: squares, sum, divider, square roots, output.
//
//  channel  | handshake           | word
//  ---------+---------------------+------------------------------------------
//  input    | in_valid, in_stall  | comp_x, comp_y, comp_z
//  output   | out_valid, out_stall| unit_x, unit_y, unit_z, length, was_zero
//
// One word enters per cycle while in_stall is low; the path is 3 front stages, 63 divider
// stages at one quotient bit each, 32 root stages at one root bit each, then the output.
// Reset clears only the valid bits and the output/skid flags.
// in_stall comes straight from the skid register, so once an output stall sends a word to
// the skid, the whole pipeline freezes from the next cycle while the skid word holds it.
`default_nettype none
module vector_normalise_3d_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [vn3_pkg::COMP_W-1:0]    comp_x,
    input  wire logic signed [vn3_pkg::COMP_W-1:0]    comp_y,
    input  wire logic signed [vn3_pkg::COMP_W-1:0]    comp_z,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [vn3_pkg::COMP_W-1:0]         unit_x,
    output logic signed [vn3_pkg::COMP_W-1:0]         unit_y,
    output logic signed [vn3_pkg::COMP_W-1:0]         unit_z,
    output logic        [vn3_pkg::COMP_W-1:0]         length,
    output logic                                      was_zero
);

    localparam int NC = vn3_pkg::NCOMP;
    localparam int SW = vn3_pkg::SUM_W;
    localparam int MW = vn3_pkg::MAG_W;
    localparam int RW = vn3_pkg::ROOT_W;
    localparam int CW = vn3_pkg::COMP_W;

    logic en;

    // front stages
    logic                     v1_reg, v2_reg, v3_reg;
    logic [NC-1:0][MW-1:0]    mag_reg;
    logic [NC-1:0]            neg1_reg, neg2_reg, neg3_reg;
    logic                     zero2_reg, zero3_reg;
    logic [NC-1:0][SW-1:0]    sq_reg, sq3_reg;
    logic [SW-1:0]            sum_reg;

    logic [NC-1:0][CW-1:0]    comp_in;
    logic [NC-1:0][MW-1:0]    mag_next;
    logic [NC-1:0]            neg_next;
    logic [NC-1:0][SW-1:0]    sq_next;

    assign comp_in = {comp_z, comp_y, comp_x};

    // take magnitudes and signs
    always_comb
    begin
        for (int l = 0; l < NC; l++)
        begin
            neg_next[l] = comp_in[l][CW-1];
            mag_next[l] = neg_next[l] ? (~comp_in[l] + 1'b1) : comp_in[l];
        end
    end

    // square each magnitude
    always_comb
    begin
        for (int l = 0; l < NC; l++)
            sq_next[l] = SW'(mag_reg[l]) * SW'(mag_reg[l]);
    end

    // advance front valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // advance front payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            neg1_reg  <= neg_next;
            sq_reg    <= sq_next;
            neg2_reg  <= neg1_reg;
            zero2_reg <= (mag_reg == '0);
            sq3_reg   <= sq_reg;
            sum_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // divide each square, scaled by 2^62, by the sum of squares
    logic [NC-1:0][SW-1:0]            div_rem;
    logic [NC-1:0]                    div_bit;
    logic                             dv_valid;
    logic [SW-1:0]                    dv_div;
    logic [NC-1:0][vn3_pkg::QUO_W-1:0] dv_quot;
    logic [vn3_pkg::SB_W-1:0]         dv_sb;

    always_comb
    begin
        for (int l = 0; l < NC; l++)
        begin
            div_rem[l] = {1'b0, sq3_reg[l][SW-1:1]};
            div_bit[l] = sq3_reg[l][0];
        end
    end

    vn3_div_pipe #(
        .LANES (NC),
        .SBW   (vn3_pkg::SB_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_div    (sum_reg),
        .in_rem    (div_rem),
        .in_bit    (div_bit),
        .in_sb     ({zero3_reg, neg3_reg}),
        .out_valid (dv_valid),
        .out_div   (dv_div),
        .out_quot  (dv_quot),
        .out_sb    (dv_sb)
    );

    // square roots of the three quotients and of the sum
    logic [NC:0][2*RW-1:0]            rad;
    logic                             sq_valid;
    logic [NC:0][RW-1:0]              root;
    logic [NC:0][RW:0]                rem;
    logic [vn3_pkg::SB_W-1:0]         sq_sb;

    always_comb
    begin
        for (int l = 0; l < NC; l++)
            rad[l] = {1'b0, dv_quot[l]};
        rad[NC] = dv_div;
    end

    vn3_isqrt_pipe #(
        .LANES (NC + 1),
        .SBW   (vn3_pkg::SB_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in_rad    (rad),
        .in_sb     (dv_sb),
        .out_valid (sq_valid),
        .out_root  (root),
        .out_rem   (rem),
        .out_sb    (sq_sb)
    );

    // round, apply signs and the zero vector default
    vn3_pkg::result_t      fin;
    logic [NC-1:0][CW-1:0] unit_c;

    always_comb
    begin
        logic [RW:0]   up;
        logic [CW-1:0] mag_q;
        for (int l = 0; l < NC; l++)
        begin
            up        = {1'b0, root[l]} + 1'b1;
            mag_q     = up[RW:1];
            unit_c[l] = sq_sb[l] ? (~mag_q + 1'b1) : mag_q;
        end
        if (sq_sb[NC])
        begin
            fin.unit_x   = vn3_pkg::ONE_Q230;
            fin.unit_y   = '0;
            fin.unit_z   = '0;
            fin.length   = vn3_pkg::ONE_Q1616;
            fin.was_zero = 1'b1;
        end
        else
        begin
            fin.unit_x   = unit_c[0];
            fin.unit_y   = unit_c[1];
            fin.unit_z   = unit_c[2];
            fin.length   = (rem[NC] > {1'b0, root[NC]}) ? (root[NC] + 1'b1) : root[NC];
            fin.was_zero = 1'b0;
        end
    end

    // output register and skid word
    vn3_pkg::result_t out_reg, skid_reg;
    logic             out_v_reg, out_v_next;
    logic             skid_v_reg, skid_v_next;
    logic             load_out, load_skid, from_skid;

    assign en       = !skid_v_reg;
    assign in_stall = skid_v_reg;

    // steer the finished word to the output or the skid
    always_comb
    begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        load_out    = 1'b0;
        load_skid   = 1'b0;
        from_skid   = 1'b0;
        if (out_v_reg && !out_stall)
            out_v_next = 1'b0;
        if (skid_v_reg)
        begin
            if (!out_stall)
            begin
                out_v_next  = 1'b1;
                load_out    = 1'b1;
                from_skid   = 1'b1;
                skid_v_next = 1'b0;
            end
        end
        else if (sq_valid)
        begin
            if (!out_v_reg || !out_stall)
            begin
                out_v_next = 1'b1;
                load_out   = 1'b1;
            end
            else
            begin
                skid_v_next = 1'b1;
                load_skid   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_reg <= from_skid ? skid_reg : fin;
        if (load_skid)
            skid_reg <= fin;
    end

    assign out_valid = out_v_reg;
    assign unit_x    = out_reg.unit_x;
    assign unit_y    = out_reg.unit_y;
    assign unit_z    = out_reg.unit_z;
    assign length    = out_reg.length;
    assign was_zero  = out_reg.was_zero;

endmodule
`default_nettype wire

// ===== rtl/vn3_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing one divisor.
`default_nettype none
module vn3_div_pipe #(
    parameter int LANES = 3,
    parameter int SBW   = 4
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    en,
    input  wire logic                                    in_valid,
    input  wire logic [vn3_pkg::SUM_W-1:0]               in_div,
    input  wire logic [LANES-1:0][vn3_pkg::SUM_W-1:0]    in_rem,
    input  wire logic [LANES-1:0]                        in_bit,
    input  wire logic [SBW-1:0]                          in_sb,
    output logic                                         out_valid,
    output logic [vn3_pkg::SUM_W-1:0]                    out_div,
    output logic [LANES-1:0][vn3_pkg::QUO_W-1:0]         out_quot,
    output logic [SBW-1:0]                               out_sb
);

    localparam int SW = vn3_pkg::SUM_W;
    localparam int QW = vn3_pkg::QUO_W;

    logic                           v_reg   [QW];
    logic [SW-1:0]                  d_reg   [QW];
    logic [LANES-1:0][SW-1:0]       rem_reg [QW];
    logic [LANES-1:0][QW-1:0]       q_reg   [QW];
    logic [SBW-1:0]                 sb_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                       v_in;
        logic [SW-1:0]              d_in;
        logic [LANES-1:0][SW-1:0]   rem_in;
        logic [LANES-1:0][QW-1:0]   q_in;
        logic [LANES-1:0]           b_in;
        logic [SBW-1:0]             sb_in;
        logic [LANES-1:0][SW-1:0]   rem_next;
        logic [LANES-1:0][QW-1:0]   q_next;

        // pick stage input: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign d_in   = in_div;
            assign rem_in = in_rem;
            assign q_in   = '0;
            assign b_in   = in_bit;
            assign sb_in  = in_sb;
        end else begin : g_next
            assign v_in   = v_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign b_in   = '0;
            assign sb_in  = sb_reg[k-1];
        end

        // shift in one dividend bit, trial subtract, keep one quotient bit
        always_comb
        begin
            logic [SW:0] trial;
            logic [SW:0] diff;
            logic        ge;
            for (int l = 0; l < LANES; l++)
            begin
                trial       = {rem_in[l], b_in[l]};
                diff        = trial - {1'b0, d_in};
                ge          = (trial >= {1'b0, d_in});
                rem_next[l] = ge ? diff[SW-1:0] : trial[SW-1:0];
                q_next[l]   = {q_in[l][QW-2:0], ge};
            end
        end

        // advance valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_in;
        end

        // advance payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k]   <= d_in;
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                sb_reg[k]  <= sb_in;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_div   = d_reg[QW-1];
    assign out_quot  = q_reg[QW-1];
    assign out_sb    = sb_reg[QW-1];

endmodule
`default_nettype wire

// ===== rtl/vn3_isqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage, with final remainder.
`default_nettype none
module vn3_isqrt_pipe #(
    parameter int LANES = 4,
    parameter int SBW   = 4
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     en,
    input  wire logic                                     in_valid,
    input  wire logic [LANES-1:0][2*vn3_pkg::ROOT_W-1:0]  in_rad,
    input  wire logic [SBW-1:0]                           in_sb,
    output logic                                          out_valid,
    output logic [LANES-1:0][vn3_pkg::ROOT_W-1:0]         out_root,
    output logic [LANES-1:0][vn3_pkg::ROOT_W:0]           out_rem,
    output logic [SBW-1:0]                                out_sb
);

    localparam int RW = vn3_pkg::ROOT_W;

    logic                         v_reg  [RW];
    logic [LANES-1:0][2*RW-1:0]   n_reg  [RW];
    logic [LANES-1:0][RW-1:0]     r_reg  [RW];
    logic [LANES-1:0][RW:0]       rm_reg [RW];
    logic [SBW-1:0]               sb_reg [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        logic                       v_in;
        logic [LANES-1:0][2*RW-1:0] n_in;
        logic [LANES-1:0][RW-1:0]   r_in;
        logic [LANES-1:0][RW:0]     rm_in;
        logic [SBW-1:0]             sb_in;
        logic [LANES-1:0][2*RW-1:0] n_next;
        logic [LANES-1:0][RW-1:0]   r_next;
        logic [LANES-1:0][RW:0]     rm_next;

        // pick stage input: ports for the first stage, previous stage otherwise
        if (j == 0) begin : g_first
            assign v_in  = in_valid;
            assign n_in  = in_rad;
            assign r_in  = '0;
            assign rm_in = '0;
            assign sb_in = in_sb;
        end else begin : g_next
            assign v_in  = v_reg[j-1];
            assign n_in  = n_reg[j-1];
            assign r_in  = r_reg[j-1];
            assign rm_in = rm_reg[j-1];
            assign sb_in = sb_reg[j-1];
        end

        // bring down two radicand bits and try root bit one
        always_comb
        begin
            logic [RW+2:0] cur;
            logic [RW+2:0] trial;
            logic [RW+2:0] diff;
            logic          ge;
            for (int l = 0; l < LANES; l++)
            begin
                cur        = {rm_in[l], n_in[l][2*RW-1:2*RW-2]};
                trial      = {1'b0, r_in[l], 2'b01};
                diff       = cur - trial;
                ge         = (cur >= trial);
                rm_next[l] = ge ? diff[RW:0] : cur[RW:0];
                r_next[l]  = {r_in[l][RW-2:0], ge};
                n_next[l]  = {n_in[l][2*RW-3:0], 2'b00};
            end
        end

        // advance valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_in;
        end

        // advance payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[j]  <= n_next;
                r_reg[j]  <= r_next;
                rm_reg[j] <= rm_next;
                sb_reg[j] <= sb_in;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = r_reg[RW-1];
    assign out_rem   = rm_reg[RW-1];
    assign out_sb    = sb_reg[RW-1];

endmodule
`default_nettype wire

// ===== dv/tb_vector_normalise_3d_unit.sv =====
// Testbench for the 3D vector normalize unit: predicted unit vector and length checked per word.
`default_nettype none
module tb_vector_normalise_3d_unit;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_LEN  = 120;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic signed [vn3_pkg::COMP_W-1:0] comp_x;
    logic signed [vn3_pkg::COMP_W-1:0] comp_y;
    logic signed [vn3_pkg::COMP_W-1:0] comp_z;
    logic                              out_valid;
    logic                              out_stall;
    logic signed [vn3_pkg::COMP_W-1:0] unit_x;
    logic signed [vn3_pkg::COMP_W-1:0] unit_y;
    logic signed [vn3_pkg::COMP_W-1:0] unit_z;
    logic        [vn3_pkg::COMP_W-1:0] length;
    logic                              was_zero;

    vn3_pkg::result_t expected_units[$];
    int               err_count;
    int               idle_cycles;
    bit               no_gaps;
    int               hold_request;
    bit               any_accept;

    vector_normalise_3d_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .comp_x    (comp_x),
        .comp_y    (comp_y),
        .comp_z    (comp_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .unit_x    (unit_x),
        .unit_y    (unit_y),
        .unit_z    (unit_z),
        .length    (length),
        .was_zero  (was_zero)
    );

    // Generate the clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Magnitude of a Q16.16 component, with -32768.0 taken as exactly 2^31
    function automatic logic [63:0] comp_mag(input logic [31:0] c);
        return c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
    endfunction

    // Round(mag * 2^30 / sqrt(s)) by search on (2q-1)^2 * s <= mag^2 * 2^62
    function automatic logic [63:0] unit_magnitude(input logic [63:0] m, input logic [63:0] s);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  t;
        rhs = {64'd0, m * m} << 62;
        lo  = 64'd0;
        hi  = 64'h4000_0000;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 64'd1) / 64'd2;
            t   = 64'd2 * mid - 64'd1;
            lhs = {64'd0, t * t} * {64'd0, s};
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 64'd1;
        end
        return lo;
    endfunction

    // Length: square root of the sum of squares, rounded to nearest
    function automatic logic [63:0] rounded_root(input logic [63:0] s);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n   = s;
        res = 64'd0;
        b   = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        if (s - res * res > res)
            res = res + 64'd1;
        return res;
    endfunction

    // Predict the result word for one input vector
    function automatic vn3_pkg::result_t normalize_vec(input logic [31:0] x,
                                                       input logic [31:0] y,
                                                       input logic [31:0] z);
        vn3_pkg::result_t r;
        logic [63:0]      mx;
        logic [63:0]      my;
        logic [63:0]      mz;
        logic [63:0]      s;
        logic [63:0]      q;
        mx = comp_mag(x);
        my = comp_mag(y);
        mz = comp_mag(z);
        s  = mx * mx + my * my + mz * mz;
        if (s == 0)
        begin
            r.unit_x   = vn3_pkg::ONE_Q230;
            r.unit_y   = '0;
            r.unit_z   = '0;
            r.length   = vn3_pkg::ONE_Q1616;
            r.was_zero = 1'b1;
            return r;
        end
        q = unit_magnitude(mx, s);
        r.unit_x = x[31] ? -q[31:0] : q[31:0];
        q = unit_magnitude(my, s);
        r.unit_y = y[31] ? -q[31:0] : q[31:0];
        q = unit_magnitude(mz, s);
        r.unit_z = z[31] ? -q[31:0] : q[31:0];
        q = rounded_root(s);
        r.length   = q[31:0];
        r.was_zero = 1'b0;
        return r;
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        comp_x   <= x;
        comp_y   <= y;
        comp_z   <= z;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        expected_units.push_back(normalize_vec(x, y, z));
    endtask

    task automatic send_random_vec();
        logic [31:0] v[3];
        for (int i = 0; i < 3; i++)
        begin
            case ($urandom_range(0, 5))
                0: v[i] = 32'd0;
                1: v[i] = $urandom_range(0, 255) - 128;
                2: v[i] = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
                3: v[i] = $urandom >> $urandom_range(0, 31);
                default: v[i] = $urandom;
            endcase
        end
        send_vec(v[0], v[1], v[2]);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Check each result word against the oldest expectation
    initial
    begin
        vn3_pkg::result_t got;
        vn3_pkg::result_t want;
        int               gap;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                gap = hold_request;
                hold_request = 0;
            end
            else
                gap = no_gaps ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(negedge clk);
            while (!out_valid);
            got = '{unit_x, unit_y, unit_z, length, was_zero};
            @(posedge clk);
            if (expected_units.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                err_count++;
            end
            else
            begin
                want = expected_units.pop_front();
                compare_field("unit_x", want.unit_x, got.unit_x);
                compare_field("unit_y", want.unit_y, got.unit_y);
                compare_field("unit_z", want.unit_z, got.unit_z);
                compare_field("length", want.length, got.length);
                compare_field("was_zero", {31'd0, want.was_zero}, {31'd0, got.was_zero});
            end
        end
    end

    // Sample handshakes mid-cycle and count cycles with no word moving
    always @(negedge clk)
        any_accept = (in_valid && !in_stall) || (out_valid && !out_stall);

    always @(posedge clk)
    begin
        if (!rst_n || any_accept)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_directed();
        send_vec(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_vec(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        send_vec(32'h0000_0000, 32'hffff_0000, 32'h0000_0000);
        send_vec(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        send_vec(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_vec(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_vec(32'hffff_ffff, 32'h0000_0001, 32'h0000_0000);
        send_vec(32'h0003_0000, 32'h0004_0000, 32'h0000_0000);
        send_vec(32'h0000_0001, 32'h0000_0001, 32'h0000_0000);
        send_vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_vec(32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff);
        send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
        send_vec(32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
    endtask

    // Alternate stretches with and without idling on both sides
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_random_vec();
        end
        no_gaps = 1'b0;
    endtask

    // Hold the receiver off while the sender keeps offering words
    task automatic test_backpressure();
        hold_request = HOLD_LEN;
        no_gaps = 1'b1;
        for (int i = 0; i < 200; i++)
            send_random_vec();
        no_gaps = 1'b0;
    endtask

    // Pause the sender until every expected word has come back, then send 20 more words
    task automatic test_drain();
        in_valid <= 1'b0;
        wait (expected_units.size() == 0);
        @(posedge clk);
        for (int i = 0; i < 20; i++)
            send_random_vec();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        comp_x    <= '0;
        comp_y    <= '0;
        comp_z    <= '0;
        err_count    = 0;
        no_gaps      = 1'b0;
        hold_request = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600);
        test_backpressure();
        test_drain();
        test_random(700);
        in_valid <= 1'b0;
        wait (expected_units.size() == 0);
        repeat (DRAIN_LEN) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

// ===== vector_normalise_3d_unit.f =====
rtl/vn3_pkg.sv
rtl/vn3_div_pipe.sv
rtl/vn3_isqrt_pipe.sv
rtl/vector_normalise_3d_unit.sv
dv/tb_vector_normalise_3d_unit.sv
